### hdl/srsr_pkg.sv
// Shared types and codes for the selective-repeat receive window engine.
package srsr_pkg;

    localparam int SEQ_W = 31;

    localparam logic [2:0] STAT_IN_ORDER  = 3'd0;
    localparam logic [2:0] STAT_OUT_ORDER = 3'd1;
    localparam logic [2:0] STAT_DUP       = 3'd2;
    localparam logic [2:0] STAT_CORRUPT   = 3'd3;
    localparam logic [2:0] STAT_OVERFLOW  = 3'd4;
    localparam logic [2:0] STAT_FIN       = 3'd5;

    typedef struct packed {
        logic [SEQ_W-1:0] ack_number;
        logic [SEQ_W-1:0] sack_number;
        logic             finack;
        logic [2:0]       status;
        logic             store_enable;
        logic [5:0]       store_slot;
        logic             release_res;
        logic [6:0]       release_count;
    } t_result;

endpackage

### hdl/srsr_seg_if.sv
// Segment event channel: valid/ready with operation, sequence number and CRC flag.
interface srsr_seg_if;
    logic        valid;
    logic        ready;
    logic        operation;
    logic [30:0] seq_number;
    logic        crc_ok;

    modport source(output valid, output operation, output seq_number, output crc_ok,
                   input ready);
    modport sink(input valid, input operation, input seq_number, input crc_ok,
                 output ready);
endinterface

### hdl/srsr_res_if.sv
// Acknowledgement result channel: valid/ready with ACK, SACK and release fields.
interface srsr_res_if;
    logic        valid;
    logic        ready;
    logic [30:0] ack_number;
    logic [30:0] sack_number;
    logic        finack;
    logic [2:0]  status;
    logic        store_enable;
    logic [5:0]  store_slot;
    logic        release_res;
    logic [6:0]  release_count;

    modport source(output valid, output ack_number, output sack_number, output finack,
                   output status, output store_enable, output store_slot,
                   output release_res, output release_count, input ready);
    modport sink(input valid, input ack_number, input sack_number, input finack,
                 input status, input store_enable, input store_slot,
                 input release_res, input release_count, output ready);
endinterface

### hdl/srsr_ram.sv
// Generic single-write, single-read RAM with registered read data.
module srsr_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 64
) (
    input  logic                                     i_clk,
    input  logic                                     i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                         i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

### hdl/srsr_engine.sv
// Window sequencer: classifies a segment, updates the slot map and walks it slot by slot.
module srsr_engine #(
    parameter int WINDOW_SLOTS = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    srsr_seg_if.sink          i_seg,
    output logic              o_res_valid,
    input  logic              i_res_ready,
    output srsr_pkg::t_result o_res
);
    import srsr_pkg::*;

    localparam int AW = (WINDOW_SLOTS > 1) ? $clog2(WINDOW_SLOTS) : 1;
    localparam int CW = $clog2(WINDOW_SLOTS + 1);
    localparam logic [AW-1:0]    LAST   = AW'(WINDOW_SLOTS - 1);
    localparam logic [CW-1:0]    W_CNT  = CW'(WINDOW_SLOTS);
    localparam logic [SEQ_W-1:0] W_SEQ  = SEQ_W'(WINDOW_SLOTS);
    localparam logic [SEQ_W:0]   W_END  = (SEQ_W + 1)'(WINDOW_SLOTS - 1);

    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,
        S_IDLE  = 6'b000010,
        S_LOOK  = 6'b000100,
        S_CHECK = 6'b001000,
        S_WALK  = 6'b010000,
        S_DONE  = 6'b100000
    } t_state;

    t_state             r_state, n_state;
    logic               r_op, r_crc;
    logic [SEQ_W-1:0]   r_seq;
    logic [SEQ_W-1:0]   r_ws, n_ws;
    logic [SEQ_W:0]     r_win_end, n_win_end;
    logic [SEQ_W-1:0]   r_cum, n_cum;
    logic [SEQ_W-1:0]   r_ack_next, n_ack_next;
    logic [CW-1:0]      r_cnt, n_cnt;
    logic [CW-1:0]      r_pos, n_pos;
    logic [AW-1:0]      r_idx, n_idx;
    logic [AW-1:0]      r_k, n_k;
    logic [CW-1:0]      r_relcnt, n_relcnt;
    logic [2:0]         r_status, n_status;
    logic               r_inorder, n_inorder;
    logic               r_store_en, n_store_en;
    logic               r_slide, n_slide;

    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic               ram_wdata;
    logic [AW-1:0]      ram_raddr;
    logic               ram_rdata;

    logic [SEQ_W-1:0]   seq_off;
    logic               above, below;
    logic [SEQ_W-1:0]   cum_new, ack_new;
    logic [CW-1:0]      idx_nxt, pos_nxt, walk_end, end_m1, cnt_inc;
    logic [31:0]        slot32, rel32;

    srsr_ram #(.WIDTH(1), .DEPTH(WINDOW_SLOTS)) u_slot_map (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign i_seg.ready = (r_state == S_IDLE);

    assign seq_off  = r_seq - r_ws;
    assign above    = {1'b0, r_seq} > r_win_end;
    assign below    = r_seq < r_ws;
    assign cum_new  = r_ws + SEQ_W'(r_k);
    assign ack_new  = r_ws + SEQ_W'(r_k) + SEQ_W'(1);
    assign idx_nxt  = CW'(r_idx) + CW'(1);
    assign pos_nxt  = r_pos + CW'(1);
    assign walk_end = ram_rdata ? pos_nxt : r_pos;
    assign end_m1   = walk_end - CW'(1);
    assign cnt_inc  = r_cnt + CW'(!ram_rdata);
    assign slot32   = 32'(r_idx);
    assign rel32    = 32'(r_relcnt);

    always_comb begin
        o_res.ack_number    = '0;
        o_res.sack_number   = '0;
        o_res.finack        = (r_status == STAT_FIN);
        o_res.status        = r_status;
        o_res.store_enable  = r_store_en;
        o_res.store_slot    = r_store_en ? slot32[5:0] : 6'd0;
        o_res.release_res   = r_slide;
        o_res.release_count = r_slide ? rel32[6:0] : 7'd0;
        if (r_status != STAT_FIN) begin
            o_res.ack_number  = r_inorder ? cum_new : r_cum;
            o_res.sack_number = (r_status == STAT_CORRUPT || r_status == STAT_OVERFLOW)
                                ? r_cum : r_seq;
        end
    end

    assign o_res_valid = (r_state == S_DONE);

    always_comb begin
        n_state    = r_state;
        n_ws       = r_ws;
        n_win_end  = r_win_end;
        n_cum      = r_cum;
        n_ack_next = r_ack_next;
        n_cnt      = r_cnt;
        n_pos      = r_pos;
        n_idx      = r_idx;
        n_k        = r_k;
        n_relcnt   = r_relcnt;
        n_status   = r_status;
        n_inorder  = r_inorder;
        n_store_en = r_store_en;
        n_slide    = r_slide;
        ram_we     = 1'b0;
        ram_waddr  = r_idx;
        ram_wdata  = 1'b1;
        ram_raddr  = '0;
        unique case (r_state)
            S_CLEAR: begin
                ram_we     = 1'b1;
                ram_waddr  = r_pos[AW-1:0];
                ram_wdata  = 1'b0;
                n_cum      = r_ws - SEQ_W'(1);
                n_ack_next = r_ws;
                n_win_end  = {1'b0, r_ws} + W_END;
                if (r_pos[AW-1:0] == LAST) begin
                    n_state = S_IDLE;
                end else begin
                    n_pos = pos_nxt;
                end
            end
            S_IDLE: begin
                if (i_seg.valid) begin
                    n_state = S_LOOK;
                end
            end
            S_LOOK: begin
                n_idx      = seq_off[AW-1:0];
                n_inorder  = 1'b0;
                n_store_en = 1'b0;
                n_slide    = 1'b0;
                n_state    = S_DONE;
                if (r_op) begin
                    n_status = STAT_FIN;
                    n_pos    = '0;
                    n_state  = S_WALK;
                end else if (!r_crc) begin
                    n_status = STAT_CORRUPT;
                end else if (above) begin
                    n_status = STAT_OVERFLOW;
                end else if (below) begin
                    n_status = STAT_DUP;
                end else begin
                    ram_raddr = seq_off[AW-1:0];
                    n_inorder = (r_seq == r_ack_next);
                    n_state   = S_CHECK;
                end
            end
            S_CHECK: begin
                if (r_inorder) begin
                    ram_we     = 1'b1;
                    n_cnt      = cnt_inc;
                    n_status   = STAT_IN_ORDER;
                    n_store_en = 1'b1;
                    n_slide    = (cnt_inc >= W_CNT);
                    n_relcnt   = W_CNT;
                    if (r_idx == LAST) begin
                        n_k     = r_idx;
                        n_state = S_DONE;
                    end else begin
                        ram_raddr = idx_nxt[AW-1:0];
                        n_pos     = idx_nxt;
                        n_state   = S_WALK;
                    end
                end else if (ram_rdata) begin
                    n_status = STAT_DUP;
                    n_state  = S_DONE;
                end else begin
                    ram_we     = 1'b1;
                    n_cnt      = cnt_inc;
                    n_status   = STAT_OUT_ORDER;
                    n_store_en = 1'b1;
                    n_state    = S_DONE;
                end
            end
            S_WALK: begin
                if (ram_rdata && (pos_nxt < W_CNT)) begin
                    ram_raddr = pos_nxt[AW-1:0];
                    n_pos     = pos_nxt;
                end else begin
                    n_state = S_DONE;
                    if (r_op) begin
                        n_relcnt = walk_end;
                        n_slide  = 1'b1;
                    end else begin
                        n_k = end_m1[AW-1:0];
                    end
                end
            end
            S_DONE: begin
                if (i_res_ready) begin
                    if (r_slide) begin
                        n_ws    = r_ws + W_SEQ;
                        n_cnt   = '0;
                        n_pos   = '0;
                        n_state = S_CLEAR;
                    end else begin
                        if (r_inorder) begin
                            n_cum      = cum_new;
                            n_ack_next = ack_new;
                        end
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_ws       <= SEQ_W'(1);
            r_win_end  <= '0;
            r_cum      <= '0;
            r_ack_next <= '0;
            r_cnt      <= '0;
            r_pos      <= '0;
            r_inorder  <= 1'b0;
            r_store_en <= 1'b0;
            r_slide    <= 1'b0;
            r_status   <= STAT_IN_ORDER;
        end else begin
            r_state    <= n_state;
            r_ws       <= n_ws;
            r_win_end  <= n_win_end;
            r_cum      <= n_cum;
            r_ack_next <= n_ack_next;
            r_cnt      <= n_cnt;
            r_pos      <= n_pos;
            r_inorder  <= n_inorder;
            r_store_en <= n_store_en;
            r_slide    <= n_slide;
            r_status   <= n_status;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx    <= n_idx;
        r_k      <= n_k;
        r_relcnt <= n_relcnt;
        if (i_seg.valid && i_seg.ready) begin
            r_op  <= i_seg.operation;
            r_seq <= i_seg.seq_number;
            r_crc <= i_seg.crc_ok;
        end
    end
endmodule

### hdl/selective_repeat_sack_receiver_top.sv
// Path from segment transfer to result: corrupt, out-of-window and below-window duplicate segments
// go from classification straight to the result; in-window segments read the slot map first; an
// in-order segment then walks the stored slots after it, and FIN walks the run that it releases.
// Segments are taken one at a time: the engine accepts the next after its result enters the output register.
// A window slide (window full or FIN) and reset (synchronous, active low) each run a
// clearing pass over every slot of the slot map; no segment is taken until it ends.
module selective_repeat_sack_receiver_top #(
    parameter int WINDOW_SLOTS = 64
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    srsr_seg_if.sink  i_seg,
    srsr_res_if.source o_res
);
    import srsr_pkg::*;

    t_result eng_res;
    logic    eng_valid;
    logic    eng_ready;
    t_result r_out;
    logic    r_out_valid;

    srsr_engine #(.WINDOW_SLOTS(WINDOW_SLOTS)) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_seg       (i_seg),
        .o_res_valid (eng_valid),
        .i_res_ready (eng_ready),
        .o_res       (eng_res)
    );

    assign eng_ready = !r_out_valid || o_res.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (eng_ready) begin
            r_out_valid <= eng_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (eng_ready && eng_valid) begin
            r_out <= eng_res;
        end
    end

    assign o_res.valid         = r_out_valid;
    assign o_res.ack_number    = r_out.ack_number;
    assign o_res.sack_number   = r_out.sack_number;
    assign o_res.finack        = r_out.finack;
    assign o_res.status        = r_out.status;
    assign o_res.store_enable  = r_out.store_enable;
    assign o_res.store_slot    = r_out.store_slot;
    assign o_res.release_res   = r_out.release_res;
    assign o_res.release_count = r_out.release_count;
endmodule

### tb/srsr_ack_checker.sv
// Checker for the receive window engine: predicts every acknowledgement and compares it.
module srsr_ack_checker #(
    parameter int WINDOW_SLOTS = 64
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    srsr_seg_if                        i_seg,
    srsr_res_if                        i_res,
    output int                         o_fail_count,
    output int                         o_pending,
    output logic [srsr_pkg::SEQ_W-1:0] o_window_start,
    output logic [srsr_pkg::SEQ_W-1:0] o_next_seq
);
    timeunit 1ns;
    timeprecision 1ps;

    import srsr_pkg::*;

    logic             slot_map [WINDOW_SLOTS];
    logic [SEQ_W-1:0] win_base;
    logic [SEQ_W-1:0] cum_ack;
    int               filled;
    int               fails = 0;
    t_result          ack_due [$];

    task automatic shift_window();
        for (int i = 0; i < WINDOW_SLOTS; i++) slot_map[i] = 1'b0;
        win_base = win_base + SEQ_W'(WINDOW_SLOTS);
        cum_ack  = win_base - 1'b1;
        filled   = 0;
    endtask

    task automatic predict_ack(input logic op, input logic [SEQ_W-1:0] seq, input logic crc,
                               output t_result r);
        logic [31:0]      win_end;
        logic [SEQ_W-1:0] next_seq;
        int               idx;
        int               run;
        r             = '0;
        win_end       = {1'b0, win_base} + 32'(WINDOW_SLOTS - 1);
        next_seq      = cum_ack + 1'b1;
        r.ack_number  = cum_ack;
        r.sack_number = cum_ack;
        if (op) begin
            for (run = 0; run < WINDOW_SLOTS; run++) begin
                if (!slot_map[run]) break;
            end
            r.ack_number    = '0;
            r.sack_number   = '0;
            r.finack        = 1'b1;
            r.status        = STAT_FIN;
            r.release_res   = 1'b1;
            r.release_count = 7'(run);
            shift_window();
        end else if (!crc) begin
            r.status = STAT_CORRUPT;
        end else if ({1'b0, seq} > win_end) begin
            r.status = STAT_OVERFLOW;
        end else if (seq < win_base) begin
            r.status      = STAT_DUP;
            r.sack_number = seq;
        end else begin
            idx           = int'(seq - win_base);
            r.sack_number = seq;
            if (seq == next_seq) begin
                if (!slot_map[idx]) begin
                    slot_map[idx] = 1'b1;
                    filled++;
                end
                r.store_enable = 1'b1;
                r.store_slot   = 6'(idx);
                r.status       = STAT_IN_ORDER;
                for (run = idx; run + 1 < WINDOW_SLOTS; run++) begin
                    if (!slot_map[run + 1]) break;
                end
                cum_ack      = win_base + SEQ_W'(run);
                r.ack_number = cum_ack;
                if (filled >= WINDOW_SLOTS) begin
                    r.release_res   = 1'b1;
                    r.release_count = 7'(WINDOW_SLOTS);
                    shift_window();
                end
            end else if (slot_map[idx]) begin
                r.status = STAT_DUP;
            end else begin
                slot_map[idx] = 1'b1;
                filled++;
                r.store_enable = 1'b1;
                r.store_slot   = 6'(idx);
                r.status       = STAT_OUT_ORDER;
            end
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            for (int i = 0; i < WINDOW_SLOTS; i++) slot_map[i] = 1'b0;
            win_base = SEQ_W'(1);
            cum_ack  = '0;
            filled   = 0;
            ack_due.delete();
        end else begin
            if (i_res.valid && i_res.ready) begin
                got.ack_number    = i_res.ack_number;
                got.sack_number   = i_res.sack_number;
                got.finack        = i_res.finack;
                got.status        = i_res.status;
                got.store_enable  = i_res.store_enable;
                got.store_slot    = i_res.store_slot;
                got.release_res   = i_res.release_res;
                got.release_count = i_res.release_count;
                if (ack_due.size() == 0) begin
                    fails++;
                    if (fails <= 10)
                        $display("%0t: unexpected result ack=%0d sack=%0d status=%0d",
                                 $realtime, got.ack_number, got.sack_number, got.status);
                end else begin
                    want = ack_due.pop_front();
                    if (got.ack_number !== want.ack_number ||
                        got.sack_number !== want.sack_number ||
                        got.finack !== want.finack ||
                        got.status !== want.status ||
                        got.store_enable !== want.store_enable ||
                        got.store_slot !== want.store_slot ||
                        got.release_res !== want.release_res ||
                        got.release_count !== want.release_count) begin
                        fails++;
                        if (fails <= 10) begin
                            $write("%0t: mismatch exp ack=%0d sack=%0d fin=%0b st=%0d",
                                   $realtime, want.ack_number, want.sack_number,
                                   want.finack, want.status);
                            $display(" en=%0b slot=%0d rel=%0b cnt=%0d",
                                     want.store_enable, want.store_slot,
                                     want.release_res, want.release_count);
                            $write("          got ack=%0d sack=%0d fin=%0b st=%0d",
                                   got.ack_number, got.sack_number, got.finack,
                                   got.status);
                            $display(" en=%0b slot=%0d rel=%0b cnt=%0d",
                                     got.store_enable, got.store_slot,
                                     got.release_res, got.release_count);
                        end
                    end
                end
            end
            if (i_seg.valid && i_seg.ready) begin
                predict_ack(i_seg.operation, i_seg.seq_number, i_seg.crc_ok, want);
                ack_due.push_back(want);
            end
        end
        o_pending      <= ack_due.size();
        o_fail_count   <= fails;
        o_window_start <= win_base;
        o_next_seq     <= cum_ack + 1'b1;
    end

endmodule

### tb/selective_repeat_sack_receiver_top_tb.sv
// Testbench top for the receive window engine: reset, segment stimulus, stalls and verdict.
module selective_repeat_sack_receiver_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import srsr_pkg::*;

    localparam int WINDOW_SLOTS = 64;
    localparam int ITEM_TARGET  = 1450;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int DRAIN_CYCLES = 2 * WINDOW_SLOTS + 16;

    logic             i_clk;
    logic             i_rst_n;
    int               fail_count;
    int               pending;
    logic [SEQ_W-1:0] window_start;
    logic [SEQ_W-1:0] next_seq;
    int               sent;
    int               burst_left;
    int               cycle_count;

    srsr_seg_if seg_ch ();
    srsr_res_if res_ch ();

    selective_repeat_sack_receiver_top #(
        .WINDOW_SLOTS(WINDOW_SLOTS)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_seg  (seg_ch),
        .o_res  (res_ch)
    );

    srsr_ack_checker #(
        .WINDOW_SLOTS(WINDOW_SLOTS)
    ) u_ack_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_seg         (seg_ch),
        .i_res         (res_ch),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_window_start(window_start),
        .o_next_seq    (next_seq)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("** selective_repeat_sack_receiver_top: FAILED **");
        $finish;
    end

    initial begin : sink_stall
        int mode;
        int left;
        int phase;
        mode         = 0;
        left         = 0;
        phase        = 0;
        res_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (left == 0) begin
                mode = $urandom_range(0, 2);
                left = $urandom_range(30, 300);
            end
            left--;
            phase = (phase + 1) % 20;
            case (mode)
                0:       res_ch.ready = 1'b1;
                1:       res_ch.ready = ($urandom_range(0, 9) < 6);
                default: res_ch.ready = (phase >= 12);
            endcase
        end
    end

    // Called and returns at a falling edge, so checker outputs are current.
    task automatic send_seg(input logic op, input logic [SEQ_W-1:0] seq, input logic crc);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            repeat (gap) begin
                seg_ch.valid = 1'b0;
                @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        seg_ch.valid      = 1'b1;
        seg_ch.operation  = op;
        seg_ch.seq_number = seq;
        seg_ch.crc_ok     = crc;
        do @(posedge i_clk); while (seg_ch.ready !== 1'b1);
        burst_left--;
        sent++;
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        seg_ch.valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        burst_left = 0;
    endtask

    task automatic send_noise(input bit allow_junk);
        case ($urandom_range(0, allow_junk ? 4 : 3))
            0: send_seg(1'b0, SEQ_W'($urandom), 1'b0);
            1: send_seg(1'b0, SEQ_W'($urandom), 1'b1);
            2: send_seg(1'b0, (window_start > 1) ?
                        SEQ_W'($urandom_range(0, int'(window_start) - 1)) : '0, 1'b1);
            3: send_seg(1'b0, window_start + SEQ_W'($urandom_range(0, WINDOW_SLOTS - 1)), 1'b1);
            default: send_seg(1'($urandom_range(0, 1)), SEQ_W'($urandom),
                              1'($urandom_range(0, 1)));
        endcase
    endtask

    initial begin : stim
        int               perm [WINDOW_SLOTS];
        int               kind;
        int               n;
        int               j;
        int               tmp;
        logic [SEQ_W-1:0] ep_base;
        i_rst_n           = 1'b0;
        seg_ch.valid      = 1'b0;
        seg_ch.operation  = 1'b0;
        seg_ch.seq_number = '0;
        seg_ch.crc_ok     = 1'b0;
        sent              = 0;
        burst_left        = 0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        send_seg(1'b0, 31'd1, 1'b1);
        send_seg(1'b0, 31'd0, 1'b1);
        send_seg(1'b0, 31'h7FFF_FFFF, 1'b1);
        send_seg(1'b0, 31'd5, 1'b0);
        send_seg(1'b0, 31'h7FFF_FFFF, 1'b0);
        send_seg(1'b0, 31'd3, 1'b1);
        send_seg(1'b0, 31'd3, 1'b1);
        send_seg(1'b0, 31'd1, 1'b1);
        send_seg(1'b0, 31'd2, 1'b1);
        send_seg(1'b0, 31'd64, 1'b1);
        send_seg(1'b0, 31'd65, 1'b1);
        send_seg(1'b1, 31'h7FFF_FFFF, 1'b0);
        send_seg(1'b1, 31'd0, 1'b1);
        send_seg(1'b0, 31'd100, 1'b1);
        send_seg(1'b0, 31'd192, 1'b1);
        send_seg(1'b0, 31'd130, 1'b1);
        send_seg(1'b0, 31'd129, 1'b1);
        send_seg(1'b0, 31'd193, 1'b1);
        send_seg(1'b0, 31'h2AAA_AAAA, 1'b1);
        send_seg(1'b0, 31'h5555_5555, 1'b1);
        send_seg(1'b1, 31'd0, 1'b0);
        wait_drained();

        while (sent < ITEM_TARGET) begin
            kind = $urandom_range(0, 99);
            if (kind < 55) begin
                // fill the whole window in a random order
                for (int i = 0; i < WINDOW_SLOTS; i++) perm[i] = i;
                for (int i = WINDOW_SLOTS - 1; i > 0; i--) begin
                    j       = $urandom_range(0, i);
                    tmp     = perm[i];
                    perm[i] = perm[j];
                    perm[j] = tmp;
                end
                ep_base = window_start;
                for (int i = 0; i < WINDOW_SLOTS; i++) begin
                    if ($urandom_range(0, 9) == 0) send_noise(1'b0);
                    send_seg(1'b0, ep_base + SEQ_W'(perm[i]), 1'b1);
                end
                if (window_start == ep_base) begin
                    if ($urandom_range(0, 1) == 0) send_seg(1'b1, SEQ_W'($urandom), 1'b1);
                    else send_seg(1'b0, next_seq, 1'b1);
                end
            end else if (kind < 80) begin
                n = $urandom_range(1, 48);
                repeat (n) begin
                    if ($urandom_range(0, 9) < 3) send_seg(1'b0, next_seq, 1'b1);
                    else send_seg(1'b0,
                                  window_start + SEQ_W'($urandom_range(0, WINDOW_SLOTS - 1)),
                                  1'b1);
                end
                send_seg(1'b1, SEQ_W'($urandom), 1'($urandom_range(0, 1)));
            end else begin
                n = $urandom_range(4, 16);
                repeat (n) send_noise(1'b1);
            end
            if ($urandom_range(0, 9) == 0) wait_drained();
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("** selective_repeat_sack_receiver_top: PASSED **");
        end else begin
            $display("** selective_repeat_sack_receiver_top: FAILED **");
        end
        $finish;
    end

endmodule

### files.f
hdl/srsr_pkg.sv
hdl/srsr_seg_if.sv
hdl/srsr_res_if.sv
hdl/srsr_ram.sv
hdl/srsr_engine.sv
hdl/selective_repeat_sack_receiver_top.sv
tb/srsr_ack_checker.sv
tb/selective_repeat_sack_receiver_top_tb.sv
